>>> rtl/fevd_pkg.sv
// fevd_pkg: shared types, register indexes and default constants for the
// frame energy voice detector. No dependencies.
package fevd_pkg;

  // Default values for the top-level parameters.
  localparam int DEF_MAX_FRAME   = 4096;
  localparam int DEF_SAMPLE_BITS = 16;
  localparam int DEF_ACC_BITS    = 48;

  // Fixed field widths.
  localparam int ALPHA_BITS     = 16;
  localparam int FRAME_LEN_BITS = 13;
  localparam int ENERGY_BITS    = 48;
  localparam int CFG_IDX_BITS   = 3;
  localparam int CFG_DATA_BITS  = 48;

  // Entries in the queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // Register values after reset.
  localparam logic                      RST_FILTER_ENABLE = 1'b1;
  localparam logic [ALPHA_BITS-1:0]     RST_ALPHA_LOW     = 16'h8000;
  localparam logic [ALPHA_BITS-1:0]     RST_ALPHA_HIGH    = 16'h8000;
  localparam logic [FRAME_LEN_BITS-1:0] RST_FRAME_LENGTH  = 13'd256;
  localparam logic [ENERGY_BITS-1:0]    RST_THRESHOLD     = '0;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_FILTER_ENABLE,
    REG_ALPHA_LOW,
    REG_ALPHA_HIGH,
    REG_FRAME_LENGTH,
    REG_ENERGY_THRESHOLD
  } fevd_reg_t;

  // Frame position of a queued sample.
  typedef struct packed {
    logic first;
    logic last;
  } fevd_tag_t;

  // Back-end sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LP_MUL,
    ST_LP_UPD,
    ST_HP_MUL,
    ST_HP_UPD,
    ST_SQ_MUL,
    ST_ACC
  } fevd_state_t;

endpackage

>>> rtl/frame_energy_voice_detector_top.sv
// frame_energy_voice_detector_top: configuration registers, front end, queue
// and back end of the frame energy voice detector.
// Depends on fevd_pkg, fevd_front, fevd_queue, fevd_back.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid / in_stall  sample
//   out      source     out_valid/out_stall  voice_detected, frame_energy
//   cfg      sink       cfg_valid/cfg_ready  cfg_index, cfg_data
//
// The back end runs pop, square and accumulate when filtering is off and for the
// first sample of a frame, and for a filtered sample pop, low-pass multiply and
// update, high-pass multiply and update, square, accumulate. Accumulate waits on a
// stalled output at frame end. The one shared multiplier sets these steps.
// A two-word queue lets the front end keep taking samples while the back end
// works or waits on a stalled result. cfg_ready is always high.
// Reset (synchronous) restores register defaults and clears filter state,
// accumulator, frame counter, queue and output valid.
module frame_energy_voice_detector_top #(
  parameter int MAX_FRAME   = fevd_pkg::DEF_MAX_FRAME,
  parameter int SAMPLE_BITS = fevd_pkg::DEF_SAMPLE_BITS,
  parameter int ACC_BITS    = fevd_pkg::DEF_ACC_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [SAMPLE_BITS-1:0]       sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                voice_detected,
  output logic [fevd_pkg::ENERGY_BITS-1:0]    frame_energy,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fevd_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [fevd_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import fevd_pkg::*;

  localparam int TAG_BITS = $bits(fevd_tag_t);
  localparam int QW       = SAMPLE_BITS + TAG_BITS;

  // Configuration registers.
  logic                      filter_enable;
  logic [ALPHA_BITS-1:0]     alpha_low;
  logic [ALPHA_BITS-1:0]     alpha_high;
  logic [FRAME_LEN_BITS-1:0] frame_length;
  logic [ENERGY_BITS-1:0]    energy_threshold;

  // Front to queue.
  logic                          q_push;
  fevd_tag_t                     f_tag;
  logic signed [SAMPLE_BITS-1:0] f_sample;
  logic                          q_full;

  // Queue to back.
  logic [QW-1:0]                 q_rdata;
  logic                          q_pop;
  logic                          q_empty;
  fevd_tag_t                     b_tag;
  logic signed [SAMPLE_BITS-1:0] b_sample;

  assign cfg_ready = 1'b1;

  // Take a register write; unknown indexes drop silently.
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_enable    <= RST_FILTER_ENABLE;
      alpha_low        <= RST_ALPHA_LOW;
      alpha_high       <= RST_ALPHA_HIGH;
      frame_length     <= RST_FRAME_LENGTH;
      energy_threshold <= RST_THRESHOLD;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FILTER_ENABLE:    filter_enable    <= cfg_data[0];
        REG_ALPHA_LOW:        alpha_low        <= cfg_data[ALPHA_BITS-1:0];
        REG_ALPHA_HIGH:       alpha_high       <= cfg_data[ALPHA_BITS-1:0];
        REG_FRAME_LENGTH:     frame_length     <= cfg_data[FRAME_LEN_BITS-1:0];
        REG_ENERGY_THRESHOLD: energy_threshold <= cfg_data[ENERGY_BITS-1:0];
        default: ;
      endcase
    end
  end

  fevd_front #(
    .MAX_FRAME   (MAX_FRAME),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sample       (sample),
    .frame_length (frame_length),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_tag        (f_tag),
    .q_sample     (f_sample)
  );

  // Queue words carry the frame tag above the sample.
  fevd_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata ({f_tag, f_sample}),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  assign b_tag    = fevd_tag_t'(q_rdata[QW-1:SAMPLE_BITS]);
  assign b_sample = $signed(q_rdata[SAMPLE_BITS-1:0]);

  fevd_back #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .ACC_BITS    (ACC_BITS)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .q_empty          (q_empty),
    .q_tag            (b_tag),
    .q_sample         (b_sample),
    .q_pop            (q_pop),
    .filter_enable    (filter_enable),
    .alpha_low        (alpha_low),
    .alpha_high       (alpha_high),
    .energy_threshold (energy_threshold),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .voice_detected   (voice_detected),
    .frame_energy     (frame_energy)
  );

endmodule

>>> rtl/fevd_front.sv
// fevd_front: accepts sample words, tracks the frame position and tags each
// sample as first and/or last of its frame. Depends on fevd_pkg.
module fevd_front #(
  parameter int MAX_FRAME   = fevd_pkg::DEF_MAX_FRAME,
  parameter int SAMPLE_BITS = fevd_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [SAMPLE_BITS-1:0]         sample,
  input  logic [fevd_pkg::FRAME_LEN_BITS-1:0]   frame_length,
  input  logic                                  q_full,
  output logic                                  q_push,
  output fevd_pkg::fevd_tag_t                   q_tag,
  output logic signed [SAMPLE_BITS-1:0]         q_sample
);
  import fevd_pkg::*;

  localparam int CW = $clog2(MAX_FRAME);
  localparam int LW = (CW + 1 > FRAME_LEN_BITS) ? CW + 1 : FRAME_LEN_BITS;

  logic [CW-1:0] cnt;
  logic [LW-1:0] len_raw;
  logic [LW-1:0] len_eff;
  logic [LW-1:0] cnt_inc;
  logic          is_last;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign q_sample = sample;

  // Clamp length: zero acts as one, oversize acts as MAX_FRAME.
  always_comb begin
    len_raw = LW'(frame_length);
    if (len_raw == '0) begin
      len_eff = LW'(1);
    end else if (len_raw > LW'(MAX_FRAME)) begin
      len_eff = LW'(MAX_FRAME);
    end else begin
      len_eff = len_raw;
    end
    cnt_inc     = LW'(cnt) + LW'(1);
    is_last     = (cnt_inc >= len_eff);
    q_tag.first = (cnt == '0);
    q_tag.last  = is_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (q_push) begin
      cnt <= is_last ? '0 : cnt_inc[CW-1:0];
    end
  end

endmodule

>>> rtl/fevd_queue.sv
// fevd_queue: small register FIFO that decouples front and back.
// DEPTH is a power of two, at least 2. Depends on nothing.
module fevd_queue #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [NW-1:0]    count;

  assign full  = (count == NW'(DEPTH));
  assign empty = (count == '0);
  assign rdata = slot[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + PW'(1);
      end
      if (pop) begin
        rptr <= rptr + PW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + NW'(1);
        2'b01:   count <= count - NW'(1);
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && empty))
    else $error("queue pop while empty");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= NW'(DEPTH))
    else $error("queue count out of range");
`endif

endmodule

>>> rtl/fevd_back.sv
// fevd_back: sequencer around one shared multiplier that runs the low-pass
// and high-pass filters, squares, accumulates and issues frame results.
// Depends on fevd_pkg.
module fevd_back #(
  parameter int SAMPLE_BITS = fevd_pkg::DEF_SAMPLE_BITS,
  parameter int ACC_BITS    = fevd_pkg::DEF_ACC_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                q_empty,
  input  fevd_pkg::fevd_tag_t                 q_tag,
  input  logic signed [SAMPLE_BITS-1:0]       q_sample,
  output logic                                q_pop,
  input  logic                                filter_enable,
  input  logic [fevd_pkg::ALPHA_BITS-1:0]     alpha_low,
  input  logic [fevd_pkg::ALPHA_BITS-1:0]     alpha_high,
  input  logic [fevd_pkg::ENERGY_BITS-1:0]    energy_threshold,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                voice_detected,
  output logic [fevd_pkg::ENERGY_BITS-1:0]    frame_energy
);
  import fevd_pkg::*;

  localparam int SB = SAMPLE_BITS;
  localparam int MA = SB + 2;
  localparam int MB = (SB + 1 > ALPHA_BITS + 1) ? SB + 1 : ALPHA_BITS + 1;
  localparam int PW = MA + MB;
  localparam int SW = ((PW > ACC_BITS) ? PW : ACC_BITS) + 1;
  localparam int EW = (ACC_BITS > ENERGY_BITS) ? ACC_BITS : ENERGY_BITS;

  localparam logic signed [PW-1:0] SAT_MAX = {{(PW-SB+1){1'b0}}, {(SB-1){1'b1}}};
  localparam logic signed [PW-1:0] SAT_MIN = {{(PW-SB+1){1'b1}}, {(SB-1){1'b0}}};
  localparam logic signed [PW-1:0] ROUND_BIAS = {{(PW-16){1'b0}}, 1'b1, 15'b0};
  localparam logic [ACC_BITS-1:0]  ACC_MAX = {ACC_BITS{1'b1}};

  function automatic logic signed [SB-1:0] sat_s(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] r;
    r = v;
    if (v > SAT_MAX) begin
      r = SAT_MAX;
    end else if (v < SAT_MIN) begin
      r = SAT_MIN;
    end
    return r[SB-1:0];
  endfunction

  fevd_state_t state;
  fevd_state_t state_next;

  // The high-pass input history always equals the low-pass output history,
  // so lpo serves both.
  logic signed [SB-1:0]   y;
  logic signed [SB-1:0]   lpo;
  logic signed [SB-1:0]   hpo;
  logic signed [MA-1:0]   hdiff;
  logic signed [PW-1:0]   prod;
  logic [ACC_BITS-1:0]    acc;
  fevd_tag_t              tag;

  logic signed [MA-1:0]   op_a;
  logic signed [MB-1:0]   op_b;
  logic signed [PW-1:0]   mul;
  logic signed [PW-1:0]   rnd_sum;
  logic signed [PW-1:0]   rnd_q;
  logic signed [PW-1:0]   lp_wide;
  logic signed [SB-1:0]   lp_new;
  logic signed [SB-1:0]   hp_new;
  logic signed [MA-1:0]   hdiff_new;
  logic [SW-1:0]          sq_ext;
  logic [ACC_BITS-1:0]    sq_c;
  logic [ACC_BITS:0]      sum_full;
  logic [ACC_BITS-1:0]    sum;
  logic [EW-1:0]          sum_w;
  logic [EW-1:0]          thr_w;
  logic                   out_free;
  logic                   acc_done;
  logic                   emit;

  // Datapath arithmetic.
  always_comb begin
    rnd_sum   = prod + ROUND_BIAS;
    rnd_q     = rnd_sum >>> 16;
    lp_wide   = rnd_q + PW'(lpo);
    lp_new    = sat_s(lp_wide);
    hp_new    = sat_s(rnd_q);
    hdiff_new = MA'(hpo) + MA'(lp_new) - MA'(lpo);

    sq_ext = SW'($unsigned(prod));
    sq_c   = (sq_ext > SW'(ACC_MAX)) ? ACC_MAX : sq_ext[ACC_BITS-1:0];
    sum_full = {1'b0, acc} + {1'b0, sq_c};
    sum      = sum_full[ACC_BITS] ? ACC_MAX : sum_full[ACC_BITS-1:0];
    sum_w    = EW'(sum);
    thr_w    = EW'(energy_threshold);

    mul = op_a * op_b;
  end

  assign out_free = !out_valid || !out_stall;

  // Next state, queue pop and multiplier operand selection.
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    acc_done   = 1'b0;
    emit       = 1'b0;
    op_a       = MA'(y);
    op_b       = MB'(y);
    case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          state_next = (filter_enable && !q_tag.first) ? ST_LP_MUL : ST_SQ_MUL;
        end
      end
      ST_LP_MUL: begin
        op_a       = MA'(y) - MA'(lpo);
        op_b       = MB'($signed({1'b0, alpha_low}));
        state_next = ST_LP_UPD;
      end
      ST_LP_UPD: state_next = ST_HP_MUL;
      ST_HP_MUL: begin
        op_a       = hdiff;
        op_b       = MB'($signed({1'b0, alpha_high}));
        state_next = ST_HP_UPD;
      end
      ST_HP_UPD: state_next = ST_SQ_MUL;
      ST_SQ_MUL: state_next = ST_ACC;
      ST_ACC: begin
        // Hold a finished frame until the output register frees up.
        acc_done = !tag.last || out_free;
        emit     = tag.last && out_free;
        if (acc_done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lpo <= '0;
      hpo <= '0;
      acc <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (q_pop && filter_enable && q_tag.first) begin
            lpo <= q_sample;
            hpo <= q_sample;
          end
        end
        ST_LP_UPD: lpo <= lp_new;
        ST_HP_UPD: hpo <= hp_new;
        ST_ACC: begin
          if (acc_done) begin
            acc <= tag.last ? '0 : sum;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (q_pop) begin
          y   <= q_sample;
          tag <= q_tag;
        end
      end
      ST_LP_MUL, ST_HP_MUL, ST_SQ_MUL: prod <= mul;
      ST_LP_UPD: hdiff <= hdiff_new;
      ST_HP_UPD: y <= hp_new;
      default: ;
    endcase
    if (emit) begin
      voice_detected <= (sum_w > thr_w);
      frame_energy   <= sum_w[ENERGY_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_square_nonneg: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ACC) |-> !prod[PW-1])
    else $error("square product negative");

  a_frame_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ACC && tag.last && out_free) |=> (acc == '0 && out_valid))
    else $error("frame end did not clear accumulator or issue result");

  a_seed: assert property (@(posedge clk) disable iff (rst)
    (q_pop && filter_enable && q_tag.first) |=> (lpo == hpo && lpo == y))
    else $error("filter state not seeded on first sample");
`endif

endmodule

>>> tb/tb_frame_energy_voice_detector_top.sv
// tb_frame_energy_voice_detector_top: self-checking bench for the frame energy voice detector.
// Predicts every frame report from the driven samples and register writes, then checks it.
// Depends on fevd_pkg and frame_energy_voice_detector_top.
`timescale 1ns / 1ps

module tb_frame_energy_voice_detector_top;
  import fevd_pkg::*;

  localparam int SAMPLE_W = DEF_SAMPLE_BITS;
  localparam int FRAME_CAP = DEF_MAX_FRAME;
  localparam logic signed [SAMPLE_W-1:0] SMP_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic signed [SAMPLE_W-1:0] SMP_MAX = ~SMP_MIN;
  localparam logic [ENERGY_BITS-1:0] ENERGY_CEIL = '1;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = CFG_IDX_BITS'(REG_ENERGY_THRESHOLD + 1);
  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_PHASES = 14;
  localparam int WORDS_PER_PHASE = 90;
  localparam int PRESSURE_WORDS = 120;
  localparam int REPORT_LIMIT = 10;
  localparam longint TIMEOUT_NS = 10_000_000;

  typedef struct {
    logic                   voice;
    logic [ENERGY_BITS-1:0] energy;
  } frame_report_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] sample = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic                       voice_detected;
  logic [ENERGY_BITS-1:0]     frame_energy;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_IDX_BITS-1:0]    cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]   cfg_data = '0;

  frame_energy_voice_detector_top dut (.*);

  // Register copy, updated when a write is accepted.
  logic                      model_filter_en = RST_FILTER_ENABLE;
  logic [ALPHA_BITS-1:0]     model_alpha_lo = RST_ALPHA_LOW;
  logic [ALPHA_BITS-1:0]     model_alpha_hi = RST_ALPHA_HIGH;
  logic [FRAME_LEN_BITS-1:0] model_frame_len = RST_FRAME_LENGTH;
  logic [ENERGY_BITS-1:0]    model_thresh = RST_THRESHOLD;

  // Filter and frame state of the detector, all cleared by reset.
  longint                    lp_out = 0;
  longint                    hp_in = 0;
  longint                    hp_out = 0;
  logic [ENERGY_BITS-1:0]    energy_acc = '0;
  int unsigned               frame_pos = 0;

  frame_report_t              frame_reports[$];   // reports owed by the block, oldest first
  logic signed [SAMPLE_W-1:0] sample_backlog[$];  // words waiting to be offered

  int     send_gap = 0;
  int     stall_left = 0;
  int     hold_left = 0;
  bit     hold_kick = 1'b0;
  bit     send_idling = 1'b1;
  bit     recv_idling = 1'b1;
  longint walk = 0;
  int     mismatches = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("FAILURE");
    $finish;
  end

  function automatic longint clamp_sample(longint v);
    if (v > SMP_MAX) return SMP_MAX;
    if (v < SMP_MIN) return SMP_MIN;
    return v;
  endfunction

  // Round half up a Q0.16 product back to sample units.
  function automatic longint scale_q16(longint v);
    return (v + (longint'(1) <<< (ALPHA_BITS - 1))) >>> ALPHA_BITS;
  endfunction

  // Advance the detector by one accepted word; queue a report when the frame closes.
  function automatic void track_sample(logic signed [SAMPLE_W-1:0] s);
    longint        x;
    longint        y;
    longint        lp;
    longint        hp;
    longint        a_lo;
    longint        a_hi;
    longint unsigned sq;
    int unsigned   len;
    frame_report_t rep;
    x = s;
    y = x;
    a_lo = model_alpha_lo;
    a_hi = model_alpha_hi;
    len = model_frame_len;
    if (len == 0) len = 1;
    if (len > FRAME_CAP) len = FRAME_CAP;
    if (model_filter_en) begin
      if (frame_pos == 0) begin
        // first word of a frame seeds both filters and passes unchanged
        lp_out = x;
        hp_in = x;
        hp_out = x;
      end else begin
        lp = clamp_sample(lp_out + scale_q16((x - lp_out) * a_lo));
        hp = clamp_sample(scale_q16((hp_out + lp - hp_in) * a_hi));
        lp_out = lp;
        hp_in = lp;
        hp_out = hp;
        y = hp;
      end
    end
    sq = y * y;
    if (ENERGY_CEIL - energy_acc < sq) energy_acc = ENERGY_CEIL;
    else energy_acc = ENERGY_BITS'(energy_acc + sq);
    frame_pos++;
    if (frame_pos >= len) begin
      rep.voice = energy_acc > model_thresh;
      rep.energy = energy_acc;
      frame_reports.push_back(rep);
      energy_acc = '0;
      frame_pos = 0;
    end
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Either a bounded random walk (audio-like) or noise with extremes and quiet words.
  function automatic logic signed [SAMPLE_W-1:0] pick_sample(bit smooth);
    int         r;
    logic [31:0] u;
    r = $urandom_range(0, 9);
    u = $urandom;
    if (smooth) begin
      if (r == 0) walk = u[0] ? SMP_MAX : SMP_MIN;
      else walk = clamp_sample(walk + int'($urandom_range(0, 4096)) - 2048);
      return walk[SAMPLE_W-1:0];
    end
    if (r == 0) return SMP_MIN;
    if (r == 1) return SMP_MAX;
    if (r == 2) return '0;
    if (r < 6) return SAMPLE_W'(int'($urandom_range(0, 512)) - 256);
    return u[SAMPLE_W-1:0];
  endfunction

  function automatic logic [ALPHA_BITS-1:0] pick_alpha();
    int          r;
    logic [31:0] u;
    r = $urandom_range(0, 7);
    u = $urandom;
    if (r == 0) return '0;
    if (r == 1) return '1;
    return u[ALPHA_BITS-1:0];
  endfunction

  function automatic logic [FRAME_LEN_BITS-1:0] pick_frame_len();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return FRAME_LEN_BITS'(1);
    if (r == 2) return FRAME_LEN_BITS'(FRAME_CAP);
    if (r == 3) return '1;
    if (r == 4)
      return FRAME_LEN_BITS'($urandom_range(FRAME_CAP + 1, (1 << FRAME_LEN_BITS) - 1));
    if (r < 15) return FRAME_LEN_BITS'($urandom_range(2, 16));
    return FRAME_LEN_BITS'($urandom_range(17, 300));
  endfunction

  // Scale the threshold with the frame so the flag goes both ways.
  function automatic logic [ENERGY_BITS-1:0] pick_threshold(logic [FRAME_LEN_BITS-1:0] len);
    int          r;
    longint      span;
    logic [63:0] u;
    r = $urandom_range(0, 9);
    u = {$urandom, $urandom};
    span = (len == 0) ? 1 : ((len > FRAME_CAP) ? FRAME_CAP : len);
    if (r == 0) return '0;
    if (r == 1) return ENERGY_CEIL;
    if (r == 2) return u[ENERGY_BITS-1:0];
    return ENERGY_BITS'(span *
                        longint'($urandom_range(0, 32'h3FFF_FFFF) >> $urandom_range(0, 8)));
  endfunction

  task automatic note_mismatch(string msg);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  // Call at a rising edge; return at the edge where the write is taken, valid still high.
  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_FILTER_ENABLE:    model_filter_en = data[0];
      REG_ALPHA_LOW:        model_alpha_lo = data[ALPHA_BITS-1:0];
      REG_ALPHA_HIGH:       model_alpha_hi = data[ALPHA_BITS-1:0];
      REG_FRAME_LENGTH:     model_frame_len = data[FRAME_LEN_BITS-1:0];
      REG_ENERGY_THRESHOLD: model_thresh = data[ENERGY_BITS-1:0];
      default: ;
    endcase
  endtask

  // Write every register, optionally poke an unused index, and return at a falling edge.
  task automatic configure(logic en, logic [ALPHA_BITS-1:0] alo, logic [ALPHA_BITS-1:0] ahi,
                           logic [FRAME_LEN_BITS-1:0] len, logic [ENERGY_BITS-1:0] thr,
                           bit spare);
    @(posedge clk);
    write_reg(REG_FILTER_ENABLE, en);
    write_reg(REG_ALPHA_LOW, alo);
    write_reg(REG_ALPHA_HIGH, ahi);
    write_reg(REG_FRAME_LENGTH, len);
    write_reg(REG_ENERGY_THRESHOLD, thr);
    if (spare) write_reg(REG_SPARE + CFG_IDX_BITS'($urandom_range(0, 2)),
                         CFG_DATA_BITS'({$urandom, $urandom}));
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Wait until every word is taken and every report is in, then let the back end drain
  // words that close no frame.
  task automatic settle();
    do @(negedge clk);
    while (sample_backlog.size() != 0 || in_valid || frame_reports.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Sender: predict each accepted word, then offer the next one after its gap.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) track_sample(sample);
      // hold a stalled word; advance only once it is taken or nothing is offered
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (sample_backlog.size() > 0) begin
          sample <= sample_backlog.pop_front();
          in_valid <= 1'b1;
          send_gap = send_idling ? pick_gap() : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, armed once by the stimulus.
  always @(posedge clk) begin
    if (rst) hold_left <= 0;
    else if (hold_kick) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // Receiver: check each taken report against the oldest owed one, then pick the stall.
  always @(posedge clk) begin : report_check
    frame_report_t want;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (frame_reports.size() == 0) begin
          note_mismatch($sformatf("report with none owed: voice %0b energy %0d",
                                  voice_detected, frame_energy));
        end else begin
          want = frame_reports.pop_front();
          if (voice_detected !== want.voice)
            note_mismatch($sformatf("voice_detected expected %0b got %0b",
                                    want.voice, voice_detected));
          if (frame_energy !== want.energy)
            note_mismatch($sformatf("frame_energy expected %0d got %0d",
                                    want.energy, frame_energy));
        end
      end
      if (stall_left > 0) stall_left--;
      else if (recv_idling && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      out_stall <= (hold_left != 0) || (stall_left > 0);
    end
  end

  initial begin : stimulus
    int                        p;
    int                        n;
    bit                        smooth;
    logic [FRAME_LEN_BITS-1:0] len;
    wait (!rst);
    @(negedge clk);

    // One-word frames at the default coefficients: every word opens its frame, so it
    // reaches the square unfiltered. Zero threshold flags anything but silence.
    configure(RST_FILTER_ENABLE, RST_ALPHA_LOW, RST_ALPHA_HIGH, FRAME_LEN_BITS'(1),
              RST_THRESHOLD, 1'b0);
    sample_backlog.push_back(SMP_MIN);
    sample_backlog.push_back(SMP_MAX);
    sample_backlog.push_back('0);
    sample_backlog.push_back(SAMPLE_W'(-1));
    sample_backlog.push_back(SAMPLE_W'(1));
    sample_backlog.push_back(16'sh5555);
    sample_backlog.push_back(16'shAAAA);
    settle();

    // Full-scale square wave at top coefficients: drive both filters into saturation.
    // A ceiling threshold can never be exceeded.
    configure(1'b1, '1, '1, FRAME_LEN_BITS'(8), ENERGY_CEIL, 1'b0);
    for (n = 0; n < 8; n++) sample_backlog.push_back(n % 2 ? SMP_MIN : SMP_MAX);
    settle();

    // Bypass with zero coefficients; a zero frame length acts as one. The threshold
    // sits one below the square of the most negative word.
    configure(1'b0, '0, '0, '0, 48'h3FFF_FFFF, 1'b1);
    sample_backlog.push_back(SMP_MIN);
    sample_backlog.push_back(SMP_MAX);
    sample_backlog.push_back('0);
    settle();

    // Oversized frame length clamps to the cap; shrinking it below the words already
    // taken closes the frame on the next word.
    configure(1'b1, 16'h1000, 16'hF000, '1, '0, 1'b0);
    for (n = 0; n < 4; n++) sample_backlog.push_back(pick_sample(1'b0));
    settle();
    configure(1'b1, 16'h1000, 16'hF000, FRAME_LEN_BITS'(3), '0, 1'b0);
    sample_backlog.push_back(SMP_MAX);
    settle();

    // Back-pressure: one report per word, sender never idles, receiver holds off long
    // enough for the block to fill up and stall its input.
    configure(1'b1, pick_alpha(), pick_alpha(), FRAME_LEN_BITS'(1),
              pick_threshold(FRAME_LEN_BITS'(1)), 1'b0);
    send_idling = 1'b0;
    for (n = 0; n < PRESSURE_WORDS; n++) sample_backlog.push_back(pick_sample(1'b0));
    hold_kick = 1'b1;
    @(negedge clk);
    hold_kick = 1'b0;
    settle();

    // Random phases: fresh settings each time; frames may straddle phases.
    for (p = 0; p < RANDOM_PHASES; p++) begin
      len = pick_frame_len();
      send_idling = $urandom_range(0, 4) != 0;
      recv_idling = $urandom_range(0, 4) != 0;
      smooth = $urandom_range(0, 1) != 0;
      configure($urandom_range(0, 3) != 0, pick_alpha(), pick_alpha(), len,
                pick_threshold(len), $urandom_range(0, 3) == 0);
      for (n = 0; n < WORDS_PER_PHASE; n++) sample_backlog.push_back(pick_sample(smooth));
      settle();
    end

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
